>>> hw/rtl/rcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcc_pkg: shared types and constants of the row cosine coherence checker
// Field widths, fixed-point constants, the row job handed from front to back,
// queue status and the back-end sequencer states.
// ----------------------------------------------------------------------------
package rcc_pkg;

    // field widths
    localparam int FIELD_W        = 24;
    localparam int VALUE_BITS_DEF = 24;
    localparam int ROW_W          = 16;
    localparam int COS_W          = 18;
    localparam int CNT_W          = 17;
    localparam int SUM_W          = 34;

    // accumulator widths
    localparam int DOT_W  = 61;
    localparam int NORM_W = 60;

    // cosine datapath: operand magnitude, limb and wide product widths
    localparam int MAG_W  = DOT_W + 1;
    localparam int LIMB_W = MAG_W / 2;
    localparam int WIDE_W = 122;

    // tensor row limit
    localparam int MAX_ROWS = 65536;

    // Q1.16 constants
    localparam logic signed [COS_W-1:0] ONE_Q16     = 18'sd65536;
    localparam logic signed [COS_W-1:0] THR_DEFAULT = 18'sd64881;

    // front to back queue
    localparam int Q_DEPTH = 4;
    localparam int QL_W    = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic signed [DOT_W-1:0] dot;
        logic [NORM_W-1:0]       norm_a;
        logic [NORM_W-1:0]       norm_b;
        logic                    tensor_end;
    } row_job_t;

    typedef struct packed {
        logic            empty;
        logic [QL_W-1:0] level;
    } q_status_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_DIV,
        B_SQRT,
        B_STAT,
        B_MEAN,
        B_OUT
    } back_state_t;

endpackage
`default_nettype wire

>>> hw/rtl/rcc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcc_front: element intake and row accumulation
// Takes one element pair per cycle unless stalled, forms products, sums the dot
// product and both squared norms with saturation and queues each row total.
// ----------------------------------------------------------------------------
module rcc_front #(
    parameter int VALUE_BITS = rcc_pkg::VALUE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic signed [rcc_pkg::FIELD_W-1:0]  first_value,
    input  logic signed [rcc_pkg::FIELD_W-1:0]  reference_value,
    input  logic                                row_end,
    input  logic                                tensor_end,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  rcc_pkg::q_status_t                  q_status,
    output logic                                push,
    output rcc_pkg::row_job_t                   push_job
);
    import rcc_pkg::*;

    localparam int PROD_W = 2 * VALUE_BITS;
    localparam logic signed [DOT_W-1:0] DOT_MAX = {1'b0, {(DOT_W-1){1'b1}}};
    localparam logic signed [DOT_W-1:0] DOT_MIN = {1'b1, {(DOT_W-1){1'b0}}};
    localparam logic [NORM_W-1:0]       NORM_MAX = {NORM_W{1'b1}};

    logic signed [VALUE_BITS-1:0] a_s;
    logic signed [VALUE_BITS-1:0] b_s;
    logic signed [PROD_W-1:0]     p_ab;
    logic signed [PROD_W-1:0]     p_aa;
    logic signed [PROD_W-1:0]     p_bb;
    logic [QL_W:0]                used;
    logic                         pending;
    logic                         accept;

    logic                         s1_valid_reg;
    logic                         s1_row_end_reg;
    logic                         s1_tend_reg;
    logic signed [PROD_W-1:0]     s1_dot_reg;
    logic [PROD_W-1:0]            s1_sqa_reg;
    logic [PROD_W-1:0]            s1_sqb_reg;

    logic signed [DOT_W-1:0]      dot_acc_reg;
    logic [NORM_W-1:0]            na_reg;
    logic [NORM_W-1:0]            nb_reg;
    logic signed [DOT_W:0]        dot_sum;
    logic signed [DOT_W-1:0]      dot_sat;
    logic [NORM_W:0]              na_sum;
    logic [NORM_W:0]              nb_sum;
    logic [NORM_W-1:0]            na_sat;
    logic [NORM_W-1:0]            nb_sat;

    // low VALUE_BITS bits of each field, sign extended by the products
    assign a_s  = first_value[VALUE_BITS-1:0];
    assign b_s  = reference_value[VALUE_BITS-1:0];
    assign p_ab = a_s * b_s;
    assign p_aa = a_s * a_s;
    assign p_bb = b_s * b_s;

    // stall while the queue could not take every row end already in flight
    assign pending  = s1_valid_reg & s1_row_end_reg;
    assign used     = {1'b0, q_status.level} + {{QL_W{1'b0}}, pending};
    assign in_stall = (used >= (QL_W+1)'(Q_DEPTH));
    assign accept   = in_valid & ~in_stall;

    // product stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_row_end_reg <= row_end;
            s1_tend_reg    <= tensor_end;
            s1_dot_reg     <= p_ab;
            s1_sqa_reg     <= unsigned'(p_aa);
            s1_sqb_reg     <= unsigned'(p_bb);
        end
    end

    // saturating accumulation
    always_comb
    begin
        dot_sum = (DOT_W+1)'(dot_acc_reg) + (DOT_W+1)'(s1_dot_reg);
        if (dot_sum > (DOT_W+1)'(DOT_MAX))
        begin
            dot_sat = DOT_MAX;
        end
        else if (dot_sum < (DOT_W+1)'(DOT_MIN))
        begin
            dot_sat = DOT_MIN;
        end
        else
        begin
            dot_sat = dot_sum[DOT_W-1:0];
        end
        na_sum = {1'b0, na_reg} + (NORM_W+1)'(s1_sqa_reg);
        nb_sum = {1'b0, nb_reg} + (NORM_W+1)'(s1_sqb_reg);
        na_sat = na_sum[NORM_W] ? NORM_MAX : na_sum[NORM_W-1:0];
        nb_sat = nb_sum[NORM_W] ? NORM_MAX : nb_sum[NORM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_acc_reg <= '0;
            na_reg      <= '0;
            nb_reg      <= '0;
        end
        else if (s1_valid_reg)
        begin
            if (s1_row_end_reg)
            begin
                dot_acc_reg <= '0;
                na_reg      <= '0;
                nb_reg      <= '0;
            end
            else
            begin
                dot_acc_reg <= dot_sat;
                na_reg      <= na_sat;
                nb_reg      <= nb_sat;
            end
        end
    end

    // row total to the queue
    assign push                = pending;
    assign push_job.dot        = dot_sat;
    assign push_job.norm_a     = na_sat;
    assign push_job.norm_b     = nb_sat;
    assign push_job.tensor_end = s1_tend_reg;

endmodule
`default_nettype wire

>>> hw/rtl/rcc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcc_queue: row job queue
// Short first-in first-out store of finished row totals between the
// accumulation front and the cosine back end.
// ----------------------------------------------------------------------------
module rcc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  rcc_pkg::row_job_t   push_job,
    input  logic                pop,
    output rcc_pkg::row_job_t   head_job,
    output rcc_pkg::q_status_t  q_status
);
    import rcc_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

    row_job_t         mem [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [QL_W-1:0]  count_reg;

    // entry store
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign head_job       = mem[rd_ptr_reg];
    assign q_status.level = count_reg;
    assign q_status.empty = (count_reg == '0);

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> count_reg < QL_W'(Q_DEPTH))
        else $error("row queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("row queue underflow");
    a_level_step: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("row queue level did not follow a push");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/rcc_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcc_back: row cosine sequencer and tensor statistics
// Per row job: limb multiplier for both wide products, restoring divide,
// digit-by-digit square root, threshold check, statistics, mean divide at
// tensor end and the output register.
// ----------------------------------------------------------------------------
module rcc_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  rcc_pkg::q_status_t                 q_status,
    input  rcc_pkg::row_job_t                  head_job,
    output logic                               pop,
    input  logic signed [rcc_pkg::COS_W-1:0]   threshold,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [rcc_pkg::ROW_W-1:0]          row_number,
    output logic signed [rcc_pkg::COS_W-1:0]   row_cosine,
    output logic                               row_flagged,
    output logic                               tensor_done,
    output logic [rcc_pkg::CNT_W-1:0]          flagged_total,
    output logic signed [rcc_pkg::COS_W-1:0]   average_cosine,
    output logic signed [rcc_pkg::COS_W-1:0]   lowest_cosine
);
    import rcc_pkg::*;

    localparam logic [16:0] MAG_ONE = 17'd65536;

    back_state_t             state_reg;
    back_state_t             state_next;
    row_job_t                job_reg;
    logic [5:0]              cnt_reg;
    logic                    phase_reg;
    logic [MAG_W-1:0]        pp_reg;
    logic [1:0]              sh_reg;
    logic [WIDE_W-1:0]       acc_reg;
    logic [WIDE_W-1:0]       p_reg;
    logic [WIDE_W-1:0]       rem_reg;
    logic [32:0]             quo_reg;
    logic [31:0]             res_reg;
    logic [16:0]             mag_reg;
    logic signed [COS_W-1:0] cos_reg;
    logic                    hit_reg;
    logic [ROW_W-1:0]        rno_reg;
    logic [CNT_W-1:0]        rows_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [COS_W-1:0] min_reg;
    logic [CNT_W-1:0]        flags_reg;
    logic [17:0]             mrem_reg;
    logic [32:0]             mq_reg;
    logic                    mneg_reg;
    logic                    out_valid_reg;

    logic                    out_load;
    logic                    head_zero;
    logic                    div_ovf;
    logic                    div_last;
    logic                    sqrt_last;

    logic signed [MAG_W-1:0] dot_ext;
    logic [MAG_W-1:0]        dmag;
    logic [MAG_W-1:0]        opx;
    logic [MAG_W-1:0]        opy;
    logic [LIMB_W-1:0]       xl;
    logic [LIMB_W-1:0]       yl;
    logic [MAG_W-1:0]        pp_next;
    logic [WIDE_W-1:0]       pp_shifted;
    logic [WIDE_W-1:0]       acc_sum;
    logic [WIDE_W-1:0]       div_trial;
    logic                    div_ge;
    logic [32:0]             quo_next;
    logic [4:0]              sq_sa;
    logic [31:0]             sq_bit;
    logic [31:0]             sq_trial;
    logic                    sq_ge;
    logic [31:0]             sq_v_next;
    logic [31:0]             res_next;
    logic signed [COS_W-1:0] cosv;
    logic signed [COS_W-1:0] thr_eff;
    logic                    hit;
    logic                    counted;
    logic signed [SUM_W-1:0] sum_upd;
    logic signed [SUM_W-1:0] sum_new;
    logic signed [SUM_W-1:0] sum_abs;
    logic [17:0]             m_trial;
    logic                    m_ge;
    logic signed [COS_W-1:0] mean_v;

    // operand selection for the limb multiplier
    always_comb
    begin
        dot_ext = MAG_W'(job_reg.dot);
        dmag    = unsigned'(dot_ext[MAG_W-1] ? -dot_ext : dot_ext);
        opx     = phase_reg ? dmag : MAG_W'(job_reg.norm_a);
        opy     = phase_reg ? dmag : MAG_W'(job_reg.norm_b);
        xl      = cnt_reg[1] ? opx[MAG_W-1:LIMB_W] : opx[LIMB_W-1:0];
        yl      = cnt_reg[0] ? opy[MAG_W-1:LIMB_W] : opy[LIMB_W-1:0];
        pp_next = MAG_W'(xl) * MAG_W'(yl);
        case (sh_reg)
            2'd0:    pp_shifted = WIDE_W'(pp_reg);
            2'd1:    pp_shifted = WIDE_W'(pp_reg) << LIMB_W;
            default: pp_shifted = WIDE_W'(pp_reg) << (2 * LIMB_W);
        endcase
        acc_sum = acc_reg + pp_shifted;
    end

    // restoring divide step: dot squared times 2^32 over the norm product
    always_comb
    begin
        div_ovf   = (rem_reg >= {p_reg[WIDE_W-2:0], 1'b0});
        div_trial = (cnt_reg == 6'd1) ? rem_reg : {rem_reg[WIDE_W-2:0], 1'b0};
        div_ge    = (div_trial >= p_reg);
        quo_next  = {quo_reg[31:0], div_ge};
        div_last  = (cnt_reg == 6'd33);
    end

    // square root step, one result bit per cycle
    always_comb
    begin
        sq_sa     = 5'd30 - {cnt_reg[3:0], 1'b0};
        sq_bit    = 32'd1 << sq_sa;
        sq_trial  = res_reg + sq_bit;
        sq_ge     = (quo_reg[31:0] >= sq_trial);
        sq_v_next = sq_ge ? quo_reg[31:0] - sq_trial : quo_reg[31:0];
        res_next  = sq_ge ? (res_reg >> 1) + sq_bit : (res_reg >> 1);
        sqrt_last = (cnt_reg == 6'd15);
    end

    // threshold check and statistics update; rows past the limit leave the sum alone
    always_comb
    begin
        cosv    = job_reg.dot[DOT_W-1] ? -COS_W'(mag_reg) : COS_W'(mag_reg);
        thr_eff = (threshold > 0) ? threshold : THR_DEFAULT;
        hit     = (cosv < thr_eff);
        counted = (rows_reg < CNT_W'(MAX_ROWS));
        sum_upd = sum_reg + SUM_W'(cosv);
        sum_new = counted ? sum_upd : sum_reg;
        sum_abs = sum_new[SUM_W-1] ? -sum_new : sum_new;
    end

    // mean divide step and signed mean
    always_comb
    begin
        m_trial = {mrem_reg[16:0], mq_reg[32]};
        m_ge    = (m_trial >= {1'b0, rows_reg});
        mean_v  = mneg_reg ? -COS_W'(mq_reg[17:0]) : COS_W'(mq_reg[17:0]);
    end

    // control strobes
    always_comb
    begin
        head_zero = (head_job.norm_a == '0) || (head_job.norm_b == '0);
        pop       = (state_reg == B_IDLE) && !q_status.empty;
        out_load  = (state_reg == B_OUT) && (!out_valid_reg || !out_stall);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_status.empty)
                begin
                    state_next = head_zero ? B_STAT : B_MUL;
                end
            end
            B_MUL:
            begin
                if (cnt_reg == 6'd4 && phase_reg)
                begin
                    state_next = B_DIV;
                end
            end
            B_DIV:
            begin
                if (cnt_reg == 6'd0 && div_ovf)
                begin
                    state_next = B_STAT;
                end
                else if (div_last)
                begin
                    state_next = quo_next[32] ? B_STAT : B_SQRT;
                end
            end
            B_SQRT:
            begin
                if (sqrt_last)
                begin
                    state_next = B_STAT;
                end
            end
            B_STAT:
            begin
                state_next = job_reg.tensor_end ? B_MEAN : B_OUT;
            end
            B_MEAN:
            begin
                if (cnt_reg == 6'd32)
                begin
                    state_next = B_OUT;
                end
            end
            B_OUT:
            begin
                if (out_load)
                begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // cosine datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                job_reg   <= head_job;
                acc_reg   <= '0;
                phase_reg <= 1'b0;
                cnt_reg   <= '0;
                if ((head_job.norm_a == '0) && (head_job.norm_b == '0))
                begin
                    mag_reg <= MAG_ONE;
                end
                else
                begin
                    mag_reg <= '0;
                end
            end
            B_MUL:
            begin
                if (cnt_reg < 6'd4)
                begin
                    pp_reg <= pp_next;
                    sh_reg <= {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
                end
                if (cnt_reg != 6'd0)
                begin
                    acc_reg <= acc_sum;
                end
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 6'd4)
                begin
                    cnt_reg <= '0;
                    acc_reg <= '0;
                    if (!phase_reg)
                    begin
                        p_reg     <= acc_sum;
                        phase_reg <= 1'b1;
                    end
                    else
                    begin
                        rem_reg <= acc_sum;
                    end
                end
            end
            B_DIV:
            begin
                if (cnt_reg == 6'd0)
                begin
                    quo_reg <= '0;
                    cnt_reg <= 6'd1;
                    if (div_ovf)
                    begin
                        mag_reg <= MAG_ONE;
                    end
                end
                else
                begin
                    rem_reg <= div_ge ? div_trial - p_reg : div_trial;
                    quo_reg <= quo_next;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (div_last)
                    begin
                        cnt_reg <= '0;
                        res_reg <= '0;
                        if (quo_next[32])
                        begin
                            mag_reg <= MAG_ONE;
                        end
                    end
                end
            end
            B_SQRT:
            begin
                quo_reg[31:0] <= sq_v_next;
                res_reg       <= res_next;
                cnt_reg       <= cnt_reg + 1'b1;
                if (sqrt_last)
                begin
                    mag_reg <= res_next[16:0];
                end
            end
            B_STAT:
            begin
                cos_reg  <= cosv;
                hit_reg  <= hit;
                cnt_reg  <= '0;
                mrem_reg <= '0;
                mq_reg   <= sum_abs[32:0];
                mneg_reg <= sum_new[SUM_W-1];
                if (counted)
                begin
                    rno_reg <= rows_reg[ROW_W-1:0];
                end
                else
                begin
                    rno_reg <= ROW_W'(MAX_ROWS - 1);
                end
            end
            B_MEAN:
            begin
                mrem_reg <= m_ge ? m_trial - {1'b0, rows_reg} : m_trial;
                mq_reg   <= {mq_reg[31:0], m_ge};
                cnt_reg  <= cnt_reg + 1'b1;
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

    // tensor statistics
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= '0;
            sum_reg   <= '0;
            min_reg   <= ONE_Q16;
            flags_reg <= '0;
        end
        else if (state_reg == B_STAT && counted)
        begin
            rows_reg <= rows_reg + 1'b1;
            sum_reg  <= sum_upd;
            if (cosv < min_reg)
            begin
                min_reg <= cosv;
            end
            if (hit)
            begin
                flags_reg <= flags_reg + 1'b1;
            end
        end
        else if (out_load && job_reg.tensor_end)
        begin
            rows_reg  <= '0;
            sum_reg   <= '0;
            min_reg   <= ONE_Q16;
            flags_reg <= '0;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            row_number  <= rno_reg;
            row_cosine  <= cos_reg;
            row_flagged <= hit_reg;
            tensor_done <= job_reg.tensor_end;
            if (job_reg.tensor_end)
            begin
                flagged_total  <= flags_reg;
                average_cosine <= mean_v;
                lowest_cosine  <= min_reg;
            end
            else
            begin
                flagged_total  <= '0;
                average_cosine <= '0;
                lowest_cosine  <= '0;
            end
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_rows_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        rows_reg <= CNT_W'(MAX_ROWS))
        else $error("row count beyond limit");
    a_mag_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_STAT |-> mag_reg <= MAG_ONE)
        else $error("cosine magnitude above one");
    a_sqrt_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_SQRT |-> !quo_reg[32])
        else $error("square root operand out of range");
    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == B_OUT)
        else $error("item shown without a finished row");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/row_cosine_coherence_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// Flow: a row total is queued from the product stage register once its row end is
//   accepted; an idle back end runs multiplier, divide, root and, at tensor end,
//   the mean divide, skipping ahead when a norm is zero or the cosine clamps.
// Throughput: one element pair per cycle while the 4-entry row queue has room;
//   the back end finishes each row before it pops the next from the queue.
// Reset: asynchronous, active low; clears accumulators, statistics, queue and
//   the threshold register (to 0.99).
// ----------------------------------------------------------------------------
// row_cosine_coherence_checker: per-row cosine similarity with tensor summary
// Front accumulates element pairs per row, a short queue decouples it from the
// back end that works out each row cosine, flag and the tensor statistics.
// ----------------------------------------------------------------------------
module row_cosine_coherence_checker #(
    parameter int VALUE_BITS = rcc_pkg::VALUE_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               flag_threshold_we,
    input  logic signed [rcc_pkg::COS_W-1:0]   flag_threshold,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [rcc_pkg::FIELD_W-1:0] first_value,
    input  logic signed [rcc_pkg::FIELD_W-1:0] reference_value,
    input  logic                               row_end,
    input  logic                               tensor_end,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [rcc_pkg::ROW_W-1:0]          row_number,
    output logic signed [rcc_pkg::COS_W-1:0]   row_cosine,
    output logic                               row_flagged,
    output logic                               tensor_done,
    output logic [rcc_pkg::CNT_W-1:0]          flagged_total,
    output logic signed [rcc_pkg::COS_W-1:0]   average_cosine,
    output logic signed [rcc_pkg::COS_W-1:0]   lowest_cosine
);
    import rcc_pkg::*;

    logic signed [COS_W-1:0] threshold_reg;
    logic                    push;
    logic                    pop;
    row_job_t                push_job;
    row_job_t                head_job;
    q_status_t               q_status;

    // threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THR_DEFAULT;
        end
        else if (flag_threshold_we)
        begin
            threshold_reg <= flag_threshold;
        end
    end

    rcc_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .first_value     (first_value),
        .reference_value (reference_value),
        .row_end         (row_end),
        .tensor_end      (tensor_end),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .q_status        (q_status),
        .push            (push),
        .push_job        (push_job)
    );

    rcc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .q_status (q_status)
    );

    rcc_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_status       (q_status),
        .head_job       (head_job),
        .pop            (pop),
        .threshold      (threshold_reg),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .row_number     (row_number),
        .row_cosine     (row_cosine),
        .row_flagged    (row_flagged),
        .tensor_done    (tensor_done),
        .flagged_total  (flagged_total),
        .average_cosine (average_cosine),
        .lowest_cosine  (lowest_cosine)
    );

endmodule
`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for row_cosine_coherence_checker
// Streams element pairs into the checker with random gaps and output stalls.
// Expected row results come from a bit-accurate cosine and statistics model
// and are compared field by field. Runs several flag thresholds, the extremes
// among them.
// ----------------------------------------------------------------------------
module tb;
    import rcc_pkg::*;

    localparam int  LIMIT_CYCLES = 2_000_000;
    localparam int  SETTLE       = 150;
    localparam logic signed [23:0] VMIN = -24'sd8388608;
    localparam logic signed [23:0] VMAX = 24'sd8388607;
    localparam longint DOT_HI  = 64'sd1152921504606846975;
    localparam longint DOT_LO  = -64'sd1152921504606846976;
    localparam longint NORM_HI = 64'sd1152921504606846975;

    // content patterns for generated rows
    typedef enum int {
        PAT_RANDOM, PAT_SMALL, PAT_SAME, PAT_NEG, PAT_NEAR, PAT_ZERO_A, PAT_ZERO_BOTH
    } pattern_t;

    typedef struct {
        logic signed [23:0] a;
        logic signed [23:0] b;
        logic               re;
        logic               te;
    } pair_t;

    typedef struct {
        logic [ROW_W-1:0]        row;
        logic signed [COS_W-1:0] cosv;
        logic                    flagged;
        logic                    done;
        logic [CNT_W-1:0]        ftotal;
        logic signed [COS_W-1:0] mean;
        logic signed [COS_W-1:0] minv;
    } row_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic thr_we = 1'b0;
    logic signed [COS_W-1:0] thr_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [FIELD_W-1:0] first_value = '0;
    logic signed [FIELD_W-1:0] reference_value = '0;
    logic row_end = 1'b0;
    logic tensor_end = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [ROW_W-1:0] row_number;
    logic signed [COS_W-1:0] row_cosine;
    logic row_flagged;
    logic tensor_done;
    logic [CNT_W-1:0] flagged_total;
    logic signed [COS_W-1:0] average_cosine;
    logic signed [COS_W-1:0] lowest_cosine;

    pair_t       pending_q[$];
    row_result_t expected_q[$];
    pair_t       driven;
    int          errors = 0;
    int          gap = 0;
    int          ostall = 0;
    int          cycles = 0;
    bit          calm = 1'b0;

    // model state
    longint          m_dot;
    longint unsigned m_na, m_nb;
    longint          m_rows, m_sum, m_min, m_flags;
    longint          m_thr;

    row_cosine_coherence_checker dut (
        .clk(clk), .rst_n(rst_n),
        .flag_threshold_we(thr_we), .flag_threshold(thr_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .first_value(first_value), .reference_value(reference_value),
        .row_end(row_end), .tensor_end(tensor_end),
        .out_valid(out_valid), .out_stall(out_stall),
        .row_number(row_number), .row_cosine(row_cosine), .row_flagged(row_flagged),
        .tensor_done(tensor_done), .flagged_total(flagged_total),
        .average_cosine(average_cosine), .lowest_cosine(lowest_cosine)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // exact cosine: largest r in [0, 1.0] with r*r*A*B <= D*D*2^32, sign of D
    function automatic longint cosine_q16(longint d, longint unsigned na,
                                          longint unsigned nb);
        logic [159:0] nn, rhs, lhs, mag, sq;
        longint lo, hi, mid;
        if (na == 0 || nb == 0)
            return (na == 0 && nb == 0) ? 65536 : 0;
        mag = (d < 0) ? 160'(-d) : 160'(d);
        nn  = 160'(na) * 160'(nb);
        rhs = (mag * mag) << 32;
        lo = 0;
        hi = 65536;
        while (lo < hi)
        begin
            mid = lo + (hi - lo + 1) / 2;
            sq  = 160'(mid * mid);
            lhs = sq * nn;
            if (lhs <= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        return (d < 0) ? -lo : lo;
    endfunction

    // fold one accepted pair into the model; a row end yields one result
    task automatic absorb_pair(pair_t p);
        longint a, b, cosv, thr;
        row_result_t r;
        a = p.a;
        b = p.b;
        m_dot = m_dot + a * b;
        if (m_dot > DOT_HI) m_dot = DOT_HI;
        if (m_dot < DOT_LO) m_dot = DOT_LO;
        m_na = m_na + longint'(a * a);
        if (m_na > NORM_HI) m_na = NORM_HI;
        m_nb = m_nb + longint'(b * b);
        if (m_nb > NORM_HI) m_nb = NORM_HI;
        if (!p.re)
            return;
        cosv = cosine_q16(m_dot, m_na, m_nb);
        m_dot = 0;
        m_na = 0;
        m_nb = 0;
        thr = (m_thr > 0) ? m_thr : 64881;
        r.cosv    = COS_W'(cosv);
        r.flagged = cosv < thr;
        if (m_rows < MAX_ROWS)
        begin
            r.row = ROW_W'(m_rows);
            m_rows++;
            m_sum += cosv;
            if (cosv < m_min) m_min = cosv;
            if (r.flagged) m_flags++;
        end
        else
            r.row = ROW_W'(MAX_ROWS - 1);
        r.done   = p.te;
        r.ftotal = '0;
        r.mean   = '0;
        r.minv   = '0;
        if (p.te)
        begin
            r.ftotal = CNT_W'(m_flags);
            r.mean   = COS_W'(m_sum / m_rows);
            r.minv   = COS_W'(m_min);
            m_rows = 0;
            m_sum = 0;
            m_min = 65536;
            m_flags = 0;
        end
        expected_q.insert(expected_q.size(), r);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // sender: one item held until accepted, random gaps between items
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                absorb_pair(driven);
            if (!in_valid || !in_stall)
            begin
                if (gap > 0)
                begin
                    gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_q.size() > 0)
                begin
                    driven = pending_q.pop_front();
                    first_value     <= driven.a;
                    reference_value <= driven.b;
                    row_end         <= driven.re;
                    tensor_end      <= driven.te;
                    in_valid        <= 1'b1;
                    gap = pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: stall runs of random length, compare each accepted result
    always @(posedge clk)
    begin
        row_result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result row %0d cosine %0d", $time,
                         row_number, row_cosine);
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (row_number !== e.row)
                begin
                    $display("%0t: row_number exp %0d got %0d", $time, e.row, row_number);
                    errors++;
                end
                if (row_cosine !== e.cosv)
                begin
                    $display("%0t: row_cosine exp %0d got %0d", $time, e.cosv, row_cosine);
                    errors++;
                end
                if (row_flagged !== e.flagged)
                begin
                    $display("%0t: row_flagged exp %0d got %0d", $time, e.flagged,
                             row_flagged);
                    errors++;
                end
                if (tensor_done !== e.done)
                begin
                    $display("%0t: tensor_done exp %0d got %0d", $time, e.done, tensor_done);
                    errors++;
                end
                if (flagged_total !== e.ftotal)
                begin
                    $display("%0t: flagged_total exp %0d got %0d", $time, e.ftotal,
                             flagged_total);
                    errors++;
                end
                if (average_cosine !== e.mean)
                begin
                    $display("%0t: average_cosine exp %0d got %0d", $time, e.mean,
                             average_cosine);
                    errors++;
                end
                if (lowest_cosine !== e.minv)
                begin
                    $display("%0t: lowest_cosine exp %0d got %0d", $time, e.minv,
                             lowest_cosine);
                    errors++;
                end
            end
        end
        if (ostall > 0)
        begin
            ostall--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
            ostall = pick_gap();
        end
    end

    // watchdog; also switches between calm and gappy stretches
    always @(posedge clk)
    begin
        cycles++;
        if ($urandom_range(0, 299) == 0)
            calm = ~calm;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic push_pair(logic signed [23:0] a, logic signed [23:0] b,
                             logic re, logic te);
        pair_t p;
        p.a = a;
        p.b = b;
        p.re = re;
        p.te = te;
        pending_q.insert(pending_q.size(), p);
    endtask

    function automatic logic signed [23:0] rnd_value(pattern_t pat);
        logic signed [23:0] v;
        v = 24'($urandom);
        if (pat == PAT_SMALL)
            v = $signed(24'($urandom_range(0, 511))) - 24'sd256;
        return v;
    endfunction

    // one row of given length and content pattern
    task automatic push_row(int len, pattern_t pat, logic te);
        logic signed [23:0] a, b;
        for (int i = 0; i < len; i++)
        begin
            a = rnd_value(pat);
            b = rnd_value(pat);
            case (pat)
                PAT_SAME:      b = a;
                PAT_NEG:       b = -a;
                PAT_NEAR:      b = a + ($signed(24'($urandom_range(0, 2047))) - 24'sd1024);
                PAT_ZERO_A:    a = '0;
                PAT_ZERO_BOTH: begin a = '0; b = '0; end
                default: ;
            endcase
            // stray tensor marks without row end are ignored by the block
            push_pair(a, b, i == len - 1,
                      (i == len - 1) ? te : ($urandom_range(0, 9) == 0));
        end
    endtask

    task automatic drain();
        wait (pending_q.size() == 0 && !in_valid && expected_q.size() == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_threshold(logic signed [COS_W-1:0] v);
        @(posedge clk);
        thr_we   <= 1'b1;
        thr_data <= v;
        @(posedge clk);
        thr_we <= 1'b0;
        m_thr = v;
    endtask

    // random phase: mostly normal rows, some long, some degenerate
    task automatic random_phase(int n_items);
        int sent, len, r;
        pattern_t pat;
        sent = 0;
        while (sent < n_items)
        begin
            r = $urandom_range(0, 99);
            len = (r < 85) ? $urandom_range(1, 8) : $urandom_range(9, 40);
            pat = pattern_t'($urandom_range(0, 6));
            push_row(len, pat, $urandom_range(0, 5) == 0);
            sent += len;
        end
        drain();
    endtask

    initial
    begin
        m_dot = 0; m_na = 0; m_nb = 0;
        m_rows = 0; m_sum = 0; m_min = 65536; m_flags = 0;
        m_thr = 64881;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, degenerate norms, single-row tensor
        push_pair(VMAX, VMAX, 1'b1, 1'b1);
        push_pair(VMIN, VMIN, 1'b0, 1'b0);
        push_pair(VMAX, VMIN, 1'b1, 1'b0);
        push_pair('0, '0, 1'b1, 1'b0);
        push_pair('0, VMAX, 1'b1, 1'b0);
        push_pair(VMIN, '0, 1'b1, 1'b0);
        push_pair(24'sd1, 24'sd1, 1'b0, 1'b1);
        push_pair(24'sd1, -24'sd1, 1'b1, 1'b0);
        push_pair(24'sd1048576, 24'sd1048575, 1'b0, 1'b0);
        push_pair(24'sd3, -24'sd7, 1'b1, 1'b1);
        push_pair(VMIN, VMAX, 1'b1, 1'b1);
        push_row(4, PAT_NEAR, 1'b0);
        push_row(3, PAT_RANDOM, 1'b1);
        drain();

        random_phase(330);
        set_threshold(-18'sd65536);
        random_phase(320);
        set_threshold('0);
        random_phase(320);
        set_threshold(18'sd65536);
        random_phase(320);
        set_threshold(18'sd1);
        random_phase(320);
        set_threshold($signed(18'($urandom_range(0, 131071))));
        random_phase(320);

        if (errors == 0 && expected_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
